### rtl/core/pcor_pkg.sv
// Shared types and constants of the Pearson correlation core.
`default_nettype none
package pcor_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int COUNT_BITS  = 16;
	localparam int FRAC_BITS   = 15;

	localparam int CNT_W  = COUNT_BITS + 1;
	localparam int SX_W   = SAMPLE_BITS + COUNT_BITS + 1;
	localparam int SXX_W  = 2 * SAMPLE_BITS + COUNT_BITS - 1;
	localparam int SXY_W  = 2 * SAMPLE_BITS + COUNT_BITS;
	localparam int COEF_W = 16;
	// quotient bits of num^2 * 2^(2F+2) / (dx*dy); ratio never exceeds 2^(2F+2)
	localparam int QUO_W  = 2 * FRAC_BITS + 3;
	localparam int ROOT_W = FRAC_BITS + 2;

	localparam logic [1:0] ST_VALID    = 2'd0;
	localparam logic [1:0] ST_ZERO_VAR = 2'd1;
	localparam logic [1:0] ST_CNT_OVF  = 2'd2;

	typedef struct packed {
		logic [CNT_W-1:0]        cnt;
		logic signed [SX_W-1:0]  sx;
		logic signed [SX_W-1:0]  sy;
		logic [SXX_W-1:0]        sxx;
		logic [SXX_W-1:0]        syy;
		logic signed [SXY_W-1:0] sxy;
		logic                    ovf;
	} pcor_snap_t;

	typedef struct packed {
		logic full;
		logic empty;
	} pcor_qstat_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_MUL,
		BK_DIV,
		BK_SQRT,
		BK_OUT
	} pcor_bk_state_t;

endpackage
`default_nettype wire

### rtl/core/pearson_correlation_core.sv
// Pearson correlation core: pair accumulator, set queue and coefficient engine.
// Pairs are taken one per clock while busy is low. On a pair marked last_sample the set
// is closed and handed to a two-set queue; busy rises only while that queue is full.
// The back end handles one set at a time (a pop, 64x16 multiply passes for eight
// products, 33 division steps, 17 square-root steps and an output state), so sets
// that arrive faster than it finishes them back up the queue. Each result appears for one cycle
// with done high and cannot be held off by the receiver.
`default_nettype none
module pearson_correlation_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic signed [15:0] sample_x,
	input  wire logic signed [15:0] sample_y,
	input  wire logic               last_sample,
	output logic                    done,
	output logic signed [15:0]      corr_coeff,
	output logic [1:0]              corr_status,
	output logic [16:0]             pair_count
);
	import pcor_pkg::*;

	logic        accept, push, pop;
	pcor_snap_t  push_data, rd_data;
	pcor_qstat_t qstat;

	assign busy   = qstat.full;
	assign accept = start & ~busy;

	pcor_front u_front (
		.clk, .arst_n, .accept, .sample_x, .sample_y, .last_sample,
		.push, .push_data
	);

	pcor_queue u_queue (
		.clk, .arst_n, .push, .push_data, .pop, .rd_data, .qstat
	);

	pcor_back u_back (
		.clk, .arst_n, .qstat, .snap(rd_data), .pop,
		.done, .corr_coeff, .corr_status, .pair_count
	);

endmodule
`default_nettype wire

### rtl/core/pcor_front.sv
// Front end: takes sample pairs, keeps running sums, hands finished sets to the queue.
`default_nettype none
module pcor_front (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      accept,
	input  wire logic signed [15:0]        sample_x,
	input  wire logic signed [15:0]        sample_y,
	input  wire logic                      last_sample,
	output logic                           push,
	output pcor_pkg::pcor_snap_t           push_data
);
	import pcor_pkg::*;

	logic [CNT_W-1:0]        cnt_q;
	logic signed [SX_W-1:0]  sx_q, sy_q;
	logic [SXX_W-1:0]        sxx_q, syy_q;
	logic signed [SXY_W-1:0] sxy_q;
	logic                    ovf_q;

	logic                    full_cnt;
	logic signed [31:0]      xx, yy, xy;
	pcor_snap_t              nxt;

	assign full_cnt = cnt_q[CNT_W-1];
	assign xx = sample_x * sample_x;
	assign yy = sample_y * sample_y;
	assign xy = sample_x * sample_y;

	always_comb begin
		nxt.cnt = cnt_q;
		nxt.sx  = sx_q;
		nxt.sy  = sy_q;
		nxt.sxx = sxx_q;
		nxt.syy = syy_q;
		nxt.sxy = sxy_q;
		nxt.ovf = ovf_q;
		if (full_cnt) begin
			nxt.ovf = 1'b1;
		end else begin
			nxt.cnt = cnt_q + CNT_W'(1);
			nxt.sx  = sx_q + SX_W'(sample_x);
			nxt.sy  = sy_q + SX_W'(sample_y);
			nxt.sxx = sxx_q + SXX_W'($unsigned(xx));
			nxt.syy = syy_q + SXX_W'($unsigned(yy));
			nxt.sxy = sxy_q + SXY_W'(xy);
		end
	end

	assign push      = accept & last_sample;
	assign push_data = nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			sx_q  <= '0;
			sy_q  <= '0;
			sxx_q <= '0;
			syy_q <= '0;
			sxy_q <= '0;
			ovf_q <= 1'b0;
		end else if (accept) begin
			if (last_sample) begin
				cnt_q <= '0;
				sx_q  <= '0;
				sy_q  <= '0;
				sxx_q <= '0;
				syy_q <= '0;
				sxy_q <= '0;
				ovf_q <= 1'b0;
			end else begin
				cnt_q <= nxt.cnt;
				sx_q  <= nxt.sx;
				sy_q  <= nxt.sy;
				sxx_q <= nxt.sxx;
				syy_q <= nxt.syy;
				sxy_q <= nxt.sxy;
				ovf_q <= nxt.ovf;
			end
		end
	end

endmodule
`default_nettype wire

### rtl/core/pcor_queue.sv
// Two-entry queue of finished set sums between front and back end.
`default_nettype none
module pcor_queue (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire pcor_pkg::pcor_snap_t push_data,
	input  wire logic                 pop,
	output pcor_pkg::pcor_snap_t      rd_data,
	output pcor_pkg::pcor_qstat_t     qstat
);
	import pcor_pkg::*;

	pcor_snap_t mem [2];
	pcor_snap_t rd_data_q;
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	assign qstat.full  = (count_q == 2'd2);
	assign qstat.empty = (count_q == 2'd0);
	assign rd_data     = rd_data_q;

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_ptr_q] <= push_data;
		if (pop)
			rd_data_q <= mem[rd_ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

### rtl/core/pcor_back.sv
// Back end: products, long division and square root that turn set sums into a coefficient.
`default_nettype none
module pcor_back (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire pcor_pkg::pcor_qstat_t qstat,
	input  wire pcor_pkg::pcor_snap_t  snap,
	output logic                       pop,
	output logic                       done,
	output logic signed [15:0]         corr_coeff,
	output logic [1:0]                 corr_status,
	output logic [16:0]                pair_count
);
	import pcor_pkg::*;

	pcor_bk_state_t state_q, state_d;

	logic [1:0]  step_q;
	logic [2:0]  op_q;
	logic [5:0]  dcnt_q;
	logic [4:0]  scnt_q;
	logic [127:0] acc_q;

	logic signed [65:0] t0_q, num_q;
	logic [63:0]  dx_q, dy_q;
	logic [125:0] dd_q, rem_q;
	logic [QUO_W-1:0] tb_q, quo_q;
	logic [2*ROOT_W-1:0] sq_q;
	logic [ROOT_W-1:0]   sres_q;
	logic [ROOT_W+2:0]   srem_q;

	logic [63:0]  mul_a, mul_b;
	logic [15:0]  chunk;
	logic [79:0]  pp;
	logic [127:0] acc_base, prod;
	logic         neg_p;
	logic signed [65:0] prod_s;
	logic [32:0]  sx_abs, sy_abs;
	logic [47:0]  sxy_abs;
	logic [65:0]  num_abs;

	logic [126:0] r2, r2_sub;
	logic         dge;
	logic [QUO_W-1:0] quo_nx;
	logic [ROOT_W+2:0] rem2, trial;
	logic         sge;
	logic [ROOT_W:0]   m_w;
	logic [ROOT_W-1:0] m;
	logic [15:0]  coeff;
	logic [1:0]   status;

	assign sx_abs  = snap.sx[SX_W-1] ? 33'(-snap.sx) : 33'(snap.sx);
	assign sy_abs  = snap.sy[SX_W-1] ? 33'(-snap.sy) : 33'(snap.sy);
	assign sxy_abs = snap.sxy[SXY_W-1] ? 48'(-snap.sxy) : 48'(snap.sxy);
	assign num_abs = num_q[65] ? 66'(-num_q) : 66'(num_q);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		neg_p = 1'b0;
		case (op_q)
			3'd0: begin mul_a = 64'(snap.cnt); mul_b = 64'(snap.sxx); end
			3'd1: begin mul_a = 64'(sx_abs);   mul_b = 64'(sx_abs); end
			3'd2: begin mul_a = 64'(snap.cnt); mul_b = 64'(snap.syy); end
			3'd3: begin mul_a = 64'(sy_abs);   mul_b = 64'(sy_abs); end
			3'd4: begin
				mul_a = 64'(snap.cnt);
				mul_b = 64'(sxy_abs);
				neg_p = snap.sxy[SXY_W-1];
			end
			3'd5: begin
				mul_a = 64'(sx_abs);
				mul_b = 64'(sy_abs);
				neg_p = snap.sx[SX_W-1] ^ snap.sy[SX_W-1];
			end
			3'd6: begin mul_a = dx_q; mul_b = dy_q; end
			3'd7: begin mul_a = num_abs[63:0]; mul_b = num_abs[63:0]; end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
		case (step_q)
			2'd0:    chunk = mul_b[15:0];
			2'd1:    chunk = mul_b[31:16];
			2'd2:    chunk = mul_b[47:32];
			default: chunk = mul_b[63:48];
		endcase
	end

	// 64x16 per cycle, accumulator shifts down so the partial product always lands on top
	assign pp       = mul_a * chunk;
	assign acc_base = (step_q == 2'd0) ? '0 : acc_q;
	assign prod     = {16'b0, acc_base[127:16]} + {pp, 48'b0};
	assign prod_s   = neg_p ? -$signed(prod[65:0]) : $signed(prod[65:0]);

	assign r2     = {rem_q, tb_q[QUO_W-1]};
	assign dge    = (r2 >= {1'b0, dd_q});
	assign r2_sub = r2 - {1'b0, dd_q};
	assign quo_nx = {quo_q[QUO_W-2:0], dge};

	assign rem2  = {srem_q[ROOT_W:0], sq_q[2*ROOT_W-1 -: 2]};
	assign trial = {1'b0, sres_q, 2'b01};
	assign sge   = (rem2 >= trial);

	// largest odd k with k^2 <= quotient is root or root-1; m = (k+1)/2
	assign m_w = ({1'b0, sres_q} + (ROOT_W+1)'(1)) >> 1;
	assign m   = m_w[ROOT_W-1:0];

	always_comb begin
		if (snap.ovf)
			status = ST_CNT_OVF;
		else if (dx_q == '0 || dy_q == '0)
			status = ST_ZERO_VAR;
		else
			status = ST_VALID;
		if (status != ST_VALID)
			coeff = '0;
		else if (num_q[65])
			coeff = 16'(-m);
		else if (m >= ROOT_W'(1 << FRAC_BITS))
			coeff = 16'((1 << FRAC_BITS) - 1);
		else
			coeff = 16'(m);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= BK_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (!qstat.empty) begin
					pop     = 1'b1;
					state_d = BK_MUL;
				end
			end
			BK_MUL:  if (op_q == 3'd7 && step_q == 2'd3) state_d = BK_DIV;
			BK_DIV:  if (dcnt_q == 6'(QUO_W - 1)) state_d = BK_SQRT;
			BK_SQRT: if (scnt_q == 5'(ROOT_W - 1)) state_d = BK_OUT;
			BK_OUT:  state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			op_q   <= '0;
			dcnt_q <= '0;
			scnt_q <= '0;
			done   <= 1'b0;
		end else begin
			done <= (state_q == BK_OUT);
			case (state_q)
				BK_IDLE: begin
					step_q <= '0;
					op_q   <= '0;
				end
				BK_MUL: begin
					step_q <= step_q + 2'd1;
					if (step_q == 2'd3)
						op_q <= op_q + 3'd1;
					dcnt_q <= '0;
				end
				BK_DIV: begin
					dcnt_q <= dcnt_q + 6'd1;
					scnt_q <= '0;
				end
				BK_SQRT: scnt_q <= scnt_q + 5'd1;
				default: step_q <= '0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			BK_MUL: begin
				acc_q <= prod;
				if (step_q == 2'd3) begin
					case (op_q)
						3'd0, 3'd2, 3'd4: t0_q <= prod_s;
						3'd1:    dx_q  <= 64'(t0_q - prod_s);
						3'd3:    dy_q  <= 64'(t0_q - prod_s);
						3'd5:    num_q <= t0_q - prod_s;
						3'd6:    dd_q  <= prod[125:0];
						default: begin
							rem_q <= {1'b0, prod[125:1]};
							tb_q  <= {prod[0], (QUO_W-1)'(0)};
							quo_q <= '0;
						end
					endcase
				end
			end
			BK_DIV: begin
				rem_q <= dge ? r2_sub[125:0] : r2[125:0];
				tb_q  <= tb_q << 1;
				quo_q <= quo_nx;
				sq_q  <= (2*ROOT_W)'(quo_nx);
				sres_q <= '0;
				srem_q <= '0;
			end
			BK_SQRT: begin
				srem_q <= sge ? rem2 - trial : rem2;
				sres_q <= {sres_q[ROOT_W-2:0], sge};
				sq_q   <= sq_q << 2;
			end
			BK_OUT: begin
				corr_coeff  <= $signed(coeff);
				corr_status <= status;
				pair_count  <= snap.cnt;
			end
			default: acc_q <= acc_q;
		endcase
	end

endmodule
`default_nettype wire

### rtl/core/pcor_checker.sv
// Port-level checks on the Pearson correlation core results.
`default_nettype none
module pcor_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               done,
	input wire logic signed [15:0] corr_coeff,
	input wire logic [1:0]         corr_status,
	input wire logic [16:0]        pair_count
);
	import pcor_pkg::*;

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (corr_status == ST_VALID || corr_status == ST_ZERO_VAR ||
			corr_status == ST_CNT_OVF))
		else $error("undefined status code");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && corr_status != ST_VALID |-> corr_coeff == 16'sd0)
		else $error("coefficient not zero on error status");

	a_valid_count: assert property (@(posedge clk) disable iff (!arst_n)
		done && corr_status == ST_VALID |-> pair_count >= 17'd2)
		else $error("valid result from fewer than two pairs");

	a_done_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("back-to-back results");

endmodule

bind pearson_correlation_core pcor_checker u_pcor_checker (.*);
`default_nettype wire

### test/pcor_checker.sv
// Request monitor, coefficient predictor and result comparator for the correlation core.
`default_nettype none
module pcor_scoreboard
	import pcor_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic               busy,
	input  wire logic signed [15:0] sample_x,
	input  wire logic signed [15:0] sample_y,
	input  wire logic               last_sample,
	input  wire logic               done,
	input  wire logic signed [15:0] corr_coeff,
	input  wire logic [1:0]         corr_status,
	input  wire logic [16:0]        pair_count,
	output int                      fail_count,
	output int                      pending
);

	typedef struct packed {
		logic [15:0] coeff;
		logic [1:0]  status;
		logic [16:0] count;
	} corr_result_t;

	corr_result_t results_due[$];

	int     acc_cnt;
	longint acc_sx, acc_sy, acc_sxx, acc_syy, acc_sxy;
	bit     acc_ovf;

	// exact rounded |r| * 2^F, ties away from zero, via binary search on squares
	function automatic logic [15:0] pearson_q15(int n, longint sx, longint sy,
			longint sxx, longint syy, longint sxy);
		logic signed [127:0] nn, num, dx, dy;
		logic [127:0] mag;
		logic [255:0] den, rhs, lhs, odd;
		int lo, hi, mid;
		nn  = n;
		dx  = nn * 128'(sxx) - 128'(sx) * 128'(sx);
		dy  = nn * 128'(syy) - 128'(sy) * 128'(sy);
		num = nn * 128'(sxy) - 128'(sx) * 128'(sy);
		mag = num[127] ? -num : num;
		den = 256'(dx) * 256'(dy);
		rhs = (256'(mag) * 256'(mag)) << (2 * FRAC_BITS + 2);
		lo = 0;
		hi = 1 << FRAC_BITS;
		while (lo < hi) begin
			mid = lo + (hi - lo + 1) / 2;
			odd = 256'(2 * mid - 1);
			lhs = den * odd * odd;
			if (lhs <= rhs)
				lo = mid;
			else
				hi = mid - 1;
		end
		if (num[127])
			return 16'(-lo);
		return (lo >= (1 << FRAC_BITS)) ? 16'((1 << FRAC_BITS) - 1) : 16'(lo);
	endfunction

	assign pending = results_due.size();

	always @(posedge clk or negedge arst_n) begin
		corr_result_t r, want;
		longint xv, yv;
		if (!arst_n) begin
			results_due.delete();
			acc_cnt = 0;
			acc_sx = 0; acc_sy = 0; acc_sxx = 0; acc_syy = 0; acc_sxy = 0;
			acc_ovf = 0;
			fail_count <= 0;
		end else begin
			if (done) begin
				if (results_due.size() == 0) begin
					$display("%0t: unexpected result coeff=%0d status=%0d count=%0d", $time,
						corr_coeff, corr_status, pair_count);
					fail_count <= fail_count + 1;
				end else begin
					want = results_due.pop_front();
					if (want.coeff !== corr_coeff || want.status !== corr_status
							|| want.count !== pair_count) begin
						$display("%0t: exp coeff=%0d st=%0d cnt=%0d got coeff=%0d st=%0d cnt=%0d",
							$time, $signed(want.coeff), want.status, want.count,
							corr_coeff, corr_status, pair_count);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (start && !busy) begin
				xv = sample_x;
				yv = sample_y;
				if (acc_cnt >= (1 << COUNT_BITS))
					acc_ovf = 1;
				else begin
					acc_cnt++;
					acc_sx += xv; acc_sy += yv;
					acc_sxx += xv * xv; acc_syy += yv * yv; acc_sxy += xv * yv;
				end
				if (last_sample) begin
					r.count = 17'(acc_cnt);
					r.coeff = '0;
					if (acc_ovf)
						r.status = ST_CNT_OVF;
					else if ((longint'(acc_cnt) * acc_sxx == acc_sx * acc_sx)
							|| (longint'(acc_cnt) * acc_syy == acc_sy * acc_sy))
						r.status = ST_ZERO_VAR;
					else begin
						r.status = ST_VALID;
						r.coeff = pearson_q15(acc_cnt, acc_sx, acc_sy, acc_sxx, acc_syy,
							acc_sxy);
					end
					results_due.insert(results_due.size(), r);
					acc_cnt = 0;
					acc_sx = 0; acc_sy = 0; acc_sxx = 0; acc_syy = 0; acc_sxy = 0;
					acc_ovf = 0;
				end
			end
		end
	end

endmodule
`default_nettype wire

### test/tb.sv
// Stimulus and verdict for the Pearson correlation core.
`default_nettype none
module tb;
	import pcor_pkg::*;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic signed [15:0] sample_x;
	logic signed [15:0] sample_y;
	logic               last_sample;
	logic               busy;
	logic               done;
	logic signed [15:0] corr_coeff;
	logic [1:0]         corr_status;
	logic [16:0]        pair_count;
	int                 fail_count;
	int                 pending;
	int                 cycle_cnt = 0;
	int                 burst_left;

	localparam int CYCLE_LIMIT = 900000;

	pearson_correlation_core dut (.*);

	pcor_scoreboard u_checker (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// one request; burst/gap pacing when paced is set
	task automatic send_pair(input logic [15:0] x, input logic [15:0] y, input bit last,
			input bit paced);
		start       <= 1'b1;
		sample_x    <= x;
		sample_y    <= y;
		last_sample <= last;
		do @(posedge clk); while (busy);
		if (paced) begin
			if (burst_left > 0)
				burst_left--;
			else begin
				start <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				burst_left = $urandom_range(0, 30);
			end
		end
	endtask

	function automatic logic [15:0] pick_sample();
		case ($urandom_range(0, 7))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return 16'(int'($urandom_range(0, 40)) - 20);
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		int len, mode;
		logic [15:0] x, y, k;
		burst_left  = 0;
		arst_n      = 0;
		start       = 0;
		sample_x    = '0;
		sample_y    = '0;
		last_sample = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// single pair, perfect +1 and -1, constant y, mixed, constant x, two pairs
		send_pair(16'h1234, 16'hbeef, 1, 0);
		send_pair(16'h7fff, 16'h7fff, 0, 0);
		send_pair(16'h8000, 16'h8000, 1, 0);
		send_pair(16'h7fff, 16'h8001, 0, 0);
		send_pair(16'h8001, 16'h7fff, 0, 1);
		send_pair(16'h0000, 16'h0000, 1, 1);
		send_pair(16'h0005, 16'h0003, 0, 1);
		send_pair(16'hfff0, 16'h0003, 0, 1);
		send_pair(16'h0100, 16'h0003, 1, 1);
		send_pair(16'h7fff, 16'h8000, 0, 0);
		send_pair(16'h8000, 16'h7fff, 0, 0);
		send_pair(16'h0001, 16'hffff, 0, 0);
		send_pair(16'h0002, 16'h0007, 1, 0);
		send_pair(16'h0003, 16'hffff, 0, 1);
		send_pair(16'h0003, 16'h0001, 1, 1);
		send_pair(16'h0004, 16'h0009, 0, 1);
		send_pair(16'hfffc, 16'h0002, 1, 1);

		for (int items = 0; items < 1550; ) begin
			len  = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 150)
				: $urandom_range(1, 8);
			mode = $urandom_range(0, 5);
			k    = 16'(int'($urandom_range(0, 6)) - 3);
			for (int i = 0; i < len; i++) begin
				x = pick_sample();
				case (mode)
					0: y = 16'(x * k + int'($urandom_range(0, 4)) - 2);
					1: y = 16'h0042;
					2: y = -x;
					default: y = pick_sample();
				endcase
				send_pair(x, y, (i == len - 1), 1);
				items++;
			end
			// stray request marked last in the middle of nothing (one-pair set)
			if ($urandom_range(0, 15) == 0) begin
				send_pair(pick_sample(), pick_sample(), 1, 1);
				items++;
			end
		end
		start <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
`default_nettype wire
